/* hdl/pcfm_pkg.sv */
// Package for the programmable byte matcher: sizes, codes and shared types.
package pcfm_pkg;

  // Table geometry.
  localparam int NUM_STATES      = 16;
  localparam int SLOTS_PER_STATE = 8;
  localparam int STATE_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int SLOT_W  = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;

  // Fixed field widths of the transaction payloads.
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int SFIELD_W = 4;
  localparam int IFIELD_W = 3;
  localparam int KIND_W  = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT_MODE = 1'd1;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_FEED   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REWIND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SLOT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FINAL  = 2'd3;

  // Rule kinds.
  localparam logic [KIND_W-1:0] KIND_NEVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ANY   = 2'd3;

  // Input transaction payload.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [BYTE_W-1:0]   byte_value;
    logic [SFIELD_W-1:0] slot_state;
    logic [IFIELD_W-1:0] slot_index;
    logic [KIND_W-1:0]   rule_kind;
    logic [SFIELD_W-1:0] dest_state;
    logic                final_flag;
  } pcfm_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic                matched;
    logic                accepted;
    logic [SFIELD_W-1:0] current_state;
  } pcfm_out_t;

  // One transition slot.
  typedef struct packed {
    logic [STATE_W-1:0] dest;
    logic [BYTE_W-1:0]  rule_byte;
    logic [KIND_W-1:0]  kind;
  } pcfm_entry_t;

  // Slot write request from the control path to the table.
  typedef struct packed {
    logic               en;
    logic [STATE_W-1:0] state;
    logic [SLOT_W-1:0]  slot;
    pcfm_entry_t        entry;
  } pcfm_slot_wr_t;

  // Outcome of the slot search for one fed byte.
  typedef struct packed {
    logic               hit;
    logic [STATE_W-1:0] dest;
  } pcfm_match_t;

endpackage

/* hdl/pcfm_slot_table.sv */
// Transition slot storage, one lane per slot position, read a whole row at a time.
module pcfm_slot_table import pcfm_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pcfm_slot_wr_t                       wr,
  input  logic [STATE_W-1:0]                  rd_state,
  output pcfm_entry_t [SLOTS_PER_STATE-1:0]   row
);

  for (genvar g = 0; g < SLOTS_PER_STATE; g++) begin : g_lane
    logic [KIND_W-1:0]              kind_r [NUM_STATES];
    logic [BYTE_W+STATE_W-1:0]      data_r [NUM_STATES];
    logic                           lane_we;

    assign lane_we = wr.en && (wr.slot == SLOT_W'(g));

    // Rule kinds reset to never, so an unwritten slot cannot match.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kind_r <= '{default: KIND_NEVER};
      end else if (lane_we) begin
        kind_r[wr.state] <= wr.entry.kind;
      end
    end

    // Rule byte and destination are only meaningful behind a live kind.
    always_ff @(posedge clk) begin
      if (lane_we) begin
        data_r[wr.state] <= {wr.entry.dest, wr.entry.rule_byte};
      end
    end

    // Row read for the present state.
    assign row[g].kind      = kind_r[rd_state];
    assign row[g].rule_byte = data_r[rd_state][BYTE_W-1:0];
    assign row[g].dest      = data_r[rd_state][BYTE_W+STATE_W-1:BYTE_W];
  end

endmodule

/* hdl/pcfm_match.sv */
// Slot search: exact rules first, then not-equal, then any; lowest slot within a kind.
module pcfm_match import pcfm_pkg::*; (
  input  pcfm_entry_t [SLOTS_PER_STATE-1:0] row,
  input  logic [BYTE_W-1:0]                 byte_value,
  output pcfm_match_t                       result
);

  logic [SLOTS_PER_STATE-1:0] hit_exact;
  logic [SLOTS_PER_STATE-1:0] hit_not;
  logic [SLOTS_PER_STATE-1:0] hit_any;
  logic [STATE_W-1:0]         dest_exact;
  logic [STATE_W-1:0]         dest_not;
  logic [STATE_W-1:0]         dest_any;

  // Per-slot hit flags for each rule kind.
  always_comb begin
    for (int i = 0; i < SLOTS_PER_STATE; i++) begin
      hit_exact[i] = (row[i].kind == KIND_EXACT) && (row[i].rule_byte == byte_value);
      hit_not[i]   = (row[i].kind == KIND_NOT) && (row[i].rule_byte != byte_value);
      hit_any[i]   = (row[i].kind == KIND_ANY);
    end
  end

  // Lowest hitting slot per kind; scanning downward lets the lowest index win.
  always_comb begin
    dest_exact = '0;
    dest_not   = '0;
    dest_any   = '0;
    for (int i = SLOTS_PER_STATE - 1; i >= 0; i--) begin
      if (hit_exact[i]) begin
        dest_exact = row[i].dest;
      end
      if (hit_not[i]) begin
        dest_not = row[i].dest;
      end
      if (hit_any[i]) begin
        dest_any = row[i].dest;
      end
    end
  end

  // Kind priority.
  always_comb begin
    result.hit = (|hit_exact) || (|hit_not) || (|hit_any);
    priority if (|hit_exact) begin
      result.dest = dest_exact;
    end else if (|hit_not) begin
      result.dest = dest_not;
    end else begin
      result.dest = dest_any;
    end
  end

endmodule

/* hdl/programmable_char_fsm_matcher.sv */
// Top level of the programmable byte matcher: input register, state, result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in_     | input     | in_valid / in_stall    | in_data  (pcfm_in_t)
//   out_    | output    | out_valid / out_stall  | out_data (pcfm_out_t)
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each transaction passes through the input register and then the result
// register; the present state's slot row is compared in parallel in between, so
// one item is accepted per cycle while the result is not stalled.
// Synchronous active-low reset sets every slot to kind never, final flags
// to zero, present state to 0 and empties both registers.
// A stalled result holds; the input register still takes an item while the
// result register is empty or being taken, so stall reaches in_stall in one step.
module programmable_char_fsm_matcher import pcfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pcfm_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pcfm_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [SFIELD_W-1:0] start_state_r;
  logic                strict_mode_r;

  // Pipeline registers.
  logic      in_valid_r;
  pcfm_in_t  in_r;
  logic      out_valid_r;
  pcfm_out_t out_r;
  pcfm_out_t out_nxt;

  // Matcher state.
  logic [STATE_W-1:0]    present_state_r;
  logic [STATE_W-1:0]    present_state_nxt;
  logic                  last_hit_r;
  logic                  last_hit_nxt;
  logic                  halted_r;
  logic                  halted_nxt;
  logic [NUM_STATES-1:0] final_flags_r;
  logic [NUM_STATES-1:0] final_flags_nxt;

  logic                                advance;
  logic                                proc_fire;
  logic [STATE_W-1:0]                  start_idx;
  logic                                feed_ok;
  pcfm_slot_wr_t                       slot_wr;
  pcfm_entry_t [SLOTS_PER_STATE-1:0]   row;
  pcfm_match_t                         match;

  // Handshakes.
  assign advance   = !out_valid_r || !out_stall;
  assign proc_fire = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      strict_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_STATE: start_state_r <= cfg_data[SFIELD_W-1:0];
        CFG_STRICT_MODE: strict_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Slot storage and search.
  assign slot_wr.en = proc_fire && (in_r.cmd == CMD_SLOT)
                      && (int'(in_r.slot_state) < NUM_STATES)
                      && (int'(in_r.dest_state) < NUM_STATES)
                      && (int'(in_r.slot_index) < SLOTS_PER_STATE);
  assign slot_wr.state           = STATE_W'(in_r.slot_state);
  assign slot_wr.slot            = SLOT_W'(in_r.slot_index);
  assign slot_wr.entry.kind      = in_r.rule_kind;
  assign slot_wr.entry.rule_byte = in_r.byte_value;
  assign slot_wr.entry.dest      = STATE_W'(in_r.dest_state);

  pcfm_slot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (slot_wr),
    .rd_state (present_state_r),
    .row      (row)
  );

  pcfm_match u_match (
    .row        (row),
    .byte_value (in_r.byte_value),
    .result     (match)
  );

  // Rewind target; an out-of-range start state falls back to state 0.
  assign start_idx = (int'(start_state_r) < NUM_STATES) ? STATE_W'(start_state_r) : '0;
  assign feed_ok   = !(halted_r && strict_mode_r);

  // Next state for the item in the input register.
  always_comb begin
    present_state_nxt = present_state_r;
    last_hit_nxt      = last_hit_r;
    halted_nxt        = halted_r;
    final_flags_nxt   = final_flags_r;
    out_nxt.matched   = 1'b0;
    unique case (in_r.cmd)
      CMD_FEED: begin
        if (feed_ok) begin
          if (match.hit) begin
            present_state_nxt = match.dest;
            last_hit_nxt      = 1'b1;
            out_nxt.matched   = 1'b1;
          end else begin
            last_hit_nxt = 1'b0;
            if (strict_mode_r) begin
              halted_nxt = 1'b1;
            end
          end
        end
      end
      CMD_REWIND: begin
        present_state_nxt = start_idx;
        last_hit_nxt      = 1'b1;
        halted_nxt        = 1'b0;
      end
      CMD_SLOT: ;
      CMD_FINAL: begin
        if (int'(in_r.slot_state) < NUM_STATES) begin
          final_flags_nxt[STATE_W'(in_r.slot_state)] = in_r.final_flag;
        end
      end
      default: ;
    endcase
    out_nxt.accepted      = final_flags_nxt[present_state_nxt]
                            && !(strict_mode_r && !last_hit_nxt);
    out_nxt.current_state = SFIELD_W'(present_state_nxt);
  end

  // State update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_state_r <= '0;
      last_hit_r      <= 1'b1;
      halted_r        <= 1'b0;
      final_flags_r   <= '0;
    end else if (proc_fire) begin
      present_state_r <= present_state_nxt;
      last_hit_r      <= last_hit_nxt;
      halted_r        <= halted_nxt;
      final_flags_r   <= final_flags_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_r <= out_nxt;
    end
  end

endmodule
